// ----- rtl/glcdpsw_pkg.sv -----
// Package for the pixel shadow writer: request codes, internal operation codes,
// the front-to-back command word and the result word. No dependencies.
package glcdpsw_pkg;

    localparam logic [1:0] REQ_SET = 2'd0;
    localparam logic [1:0] REQ_CLR = 2'd1;
    localparam logic [1:0] REQ_CHK = 2'd2;

    localparam logic [7:0] CMD_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_COLUMN = 8'h40;

    typedef enum logic [1:0] {
        OP_SET,
        OP_CLR,
        OP_CHK,
        OP_CHK_OFF
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] page;
        logic [2:0] bitpos;
        logic [7:0] colcmd;
        logic       left;
    } t_cmd;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       sel_left;
        logic       sel_right;
        logic       pixel_on;
        logic       is_check;
        logic       last;
    } t_res;

endpackage

// ----- rtl/glcdpsw_front.sv -----
// Front of the pixel shadow writer: accepts request words, classifies them and
// queues commands for the back. Depends on glcdpsw_pkg.
module glcdpsw_front #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128,
    localparam int ADDR_W = $clog2(PAGES * COLUMNS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_req_type,
    input  logic [7:0]          i_pixel_row,
    input  logic [7:0]          i_pixel_col,
    input  logic                i_busy,
    output logic                o_q_valid,
    output glcdpsw_pkg::t_cmd   o_q_cmd,
    output logic [ADDR_W-1:0]   o_q_addr,
    input  logic                i_q_pop
);
    import glcdpsw_pkg::*;

    localparam int ROWS = PAGES * 8;
    localparam int HALF = COLUMNS / 2;

    t_cmd              r_q_cmd  [2];
    logic [ADDR_W-1:0] r_q_addr [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;

    logic              on_panel;
    logic              keep;
    logic              accept;
    t_cmd              cmd;
    logic [ADDR_W-1:0] addr;

    assign on_panel = (i_pixel_row < 8'(ROWS)) && (i_pixel_col < 8'(COLUMNS));
    assign addr     = ADDR_W'(32'(i_pixel_row[5:3]) * 32'(COLUMNS) + 32'(i_pixel_col));

    always_comb begin
        cmd.page   = i_pixel_row[5:3];
        cmd.bitpos = i_pixel_row[2:0];
        cmd.left   = i_pixel_col < 8'(HALF);
        cmd.colcmd = CMD_COLUMN + (cmd.left ? i_pixel_col : i_pixel_col - 8'(HALF));
        cmd.op     = OP_SET;
        keep       = 1'b0;
        case (i_req_type)
            REQ_SET: begin
                cmd.op = OP_SET;
                keep   = on_panel;
            end
            REQ_CLR: begin
                cmd.op = OP_CLR;
                keep   = on_panel;
            end
            REQ_CHK: begin
                cmd.op = on_panel ? OP_CHK : OP_CHK_OFF;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_full    = (r_cnt == 2'd2) || i_busy;
    assign accept    = i_push && !o_full;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_cmd   = r_q_cmd[r_rd];
    assign o_q_addr  = r_q_addr[r_rd];

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q_cmd[r_wr]  <= cmd;
            r_q_addr[r_wr] <= addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept && keep) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'((accept && keep) ? 1 : 0) - 2'(i_q_pop ? 1 : 0);
        end
    end

endmodule

// ----- rtl/glcdpsw_rfifo.sv -----
// Result queue of the pixel shadow writer: four result words, push/full in,
// pop/empty out. Depends on glcdpsw_pkg.
module glcdpsw_rfifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  glcdpsw_pkg::t_res i_res,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output glcdpsw_pkg::t_res o_res
);
    import glcdpsw_pkg::*;

    t_res       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(do_push ? 1 : 0) - 3'(do_pop ? 1 : 0);
        end
    end

endmodule

// ----- rtl/glcdpsw_back.sv -----
// Back of the pixel shadow writer: frame store, clearing pass, read-modify-write
// and the three-word bus sequence. Depends on glcdpsw_pkg.
module glcdpsw_back #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128,
    localparam int ADDR_W = $clog2(PAGES * COLUMNS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_busy,
    input  logic                i_q_valid,
    input  glcdpsw_pkg::t_cmd   i_q_cmd,
    input  logic [ADDR_W-1:0]   i_q_addr,
    output logic                o_q_pop,
    output logic                o_res_push,
    output glcdpsw_pkg::t_res   o_res,
    input  logic                i_res_full
);
    import glcdpsw_pkg::*;

    localparam int DEPTH = PAGES * COLUMNS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_EMIT
    } t_state;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [1:0]        r_cnt;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_val;
    logic              r_on;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              is_chk;
    logic              last_phase;
    logic              take;
    logic [7:0]        mask;
    logic [7:0]        new_val;

    assign is_chk     = (r_cmd.op == OP_CHK) || (r_cmd.op == OP_CHK_OFF);
    assign last_phase = is_chk || (r_cnt == 2'd2);
    assign mask       = 8'd1 << r_cmd.bitpos;
    assign new_val    = (r_cmd.op == OP_SET) ? (r_rd_data | mask) : (r_rd_data & ~mask);
    assign take       = i_q_valid && ((r_state == S_IDLE) ||
                        ((r_state == S_EMIT) && last_phase && !i_res_full));
    assign o_q_pop    = take;
    assign o_busy     = r_state == S_CLEAR;

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = new_val;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'd0;
            end
            S_MOD: begin
                if (!is_chk) begin
                    mem_we           = !i_res_full;
                    o_res_push       = !i_res_full;
                    o_res.bus_byte   = CMD_PAGE + {5'd0, r_cmd.page};
                    o_res.sel_left   = 1'b1;
                    o_res.sel_right  = 1'b1;
                end
            end
            S_EMIT: begin
                o_res_push = !i_res_full;
                if (is_chk) begin
                    o_res.pixel_on = r_on;
                    o_res.is_check = 1'b1;
                    o_res.last     = 1'b1;
                end else begin
                    o_res.sel_left  = r_cmd.left;
                    o_res.sel_right = !r_cmd.left;
                    if (r_cnt == 2'd2) begin
                        o_res.bus_byte = r_val;
                        o_res.is_data  = 1'b1;
                        o_res.last     = 1'b1;
                    end else begin
                        o_res.bus_byte = r_cmd.colcmd;
                    end
                end
            end
            default: o_res_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (take) begin
            r_rd_data <= r_mem[i_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= 2'd0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_cmd   <= i_q_cmd;
                        r_addr  <= i_q_addr;
                        r_on    <= 1'b0;
                        r_state <= (i_q_cmd.op == OP_CHK_OFF) ? S_EMIT : S_MOD;
                    end
                end
                S_MOD: begin
                    if (is_chk) begin
                        r_on    <= r_rd_data[r_cmd.bitpos];
                        r_state <= S_EMIT;
                    end else if (!i_res_full) begin
                        r_val   <= new_val;
                        r_cnt   <= 2'd1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        if (!last_phase) begin
                            r_cnt <= r_cnt + 2'd1;
                        end else if (take) begin
                            r_cmd   <= i_q_cmd;
                            r_addr  <= i_q_addr;
                            r_on    <= 1'b0;
                            r_state <= (i_q_cmd.op == OP_CHK_OFF) ? S_EMIT : S_MOD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("command taken during clearing pass");

    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_CLEAR) || ((r_state == S_MOD) && !is_chk)))
        else $error("frame store written outside clear or modify");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_mod_to_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOD) && !is_chk && !i_res_full)
        |=> ((r_state == S_EMIT) && (r_cnt == 2'd1)))
        else $error("column word does not follow page word");

endmodule

// ----- rtl/glcd_pixel_shadow_writer_core.sv -----
// Top level of the pixel shadow writer: front, back with frame store, and
// result queue. Depends on glcdpsw_pkg, glcdpsw_front, glcdpsw_back, glcdpsw_rfifo.
//
//   channel   direction   handshake        payload
//   request   in          i_push / o_full  i_req_type, i_pixel_row, i_pixel_col
//   result    out         i_pop / o_empty  o_bus_byte, o_is_data, o_sel_left,
//                                           o_sel_right, o_pixel_on, o_is_check, o_last
//
// A set or clear runs in the back as modify plus two more bus words; a check on the
// panel runs as read then answer, and off it as answer only. The single-port
// read-modify-write sequencer sets these steps.
// After reset a clearing pass over all PAGES*COLUMNS entries (1024 by default) zeros the
// frame store; o_full stays high until it ends.
// Dropped requests (code 3, set or clear off the panel) give no result word.
// A two-word command queue and a four-word result queue let each side stall alone.
module glcd_pixel_shadow_writer_core #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_pixel_row,
    input  logic [7:0] i_pixel_col,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_bus_byte,
    output logic       o_is_data,
    output logic       o_sel_left,
    output logic       o_sel_right,
    output logic       o_pixel_on,
    output logic       o_is_check,
    output logic       o_last
);
    import glcdpsw_pkg::*;

    localparam int ADDR_W = $clog2(PAGES * COLUMNS);

    logic              busy;
    logic              q_valid;
    t_cmd              q_cmd;
    logic [ADDR_W-1:0] q_addr;
    logic              q_pop;
    logic              res_push;
    t_res              res_in;
    logic              res_full;
    t_res              res_out;

    glcdpsw_front #(.PAGES(PAGES), .COLUMNS(COLUMNS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_req_type  (i_req_type),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_busy      (busy),
        .o_q_valid   (q_valid),
        .o_q_cmd     (q_cmd),
        .o_q_addr    (q_addr),
        .i_q_pop     (q_pop)
    );

    glcdpsw_back #(.PAGES(PAGES), .COLUMNS(COLUMNS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_busy     (busy),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .i_q_addr   (q_addr),
        .o_q_pop    (q_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    glcdpsw_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (res_out)
    );

    assign o_bus_byte  = res_out.bus_byte;
    assign o_is_data   = res_out.is_data;
    assign o_sel_left  = res_out.sel_left;
    assign o_sel_right = res_out.sel_right;
    assign o_pixel_on  = res_out.pixel_on;
    assign o_is_check  = res_out.is_check;
    assign o_last      = res_out.last;

endmodule
